// ----- rtl/xrr_pkg.sv -----
// shared types, constants and helpers for the ranged random generator
package xrr_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned SeedSteps = 16;
  localparam int unsigned SeedCntW  = 5;

  typedef logic [WordW-1:0]        word_t;
  typedef logic signed [WordW-1:0] sword_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSeedFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeedSecond = 2'd1;

  // fixed fill word loaded into state word one on reseed
  localparam word_t SeedFill = 64'h0000_0000_0000_00ff;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_MUL5,
    ST_MUL9,
    ST_CMP,
    ST_ADD
  } xrr_state_e;

  // control from the sequencer to the generator
  typedef struct packed {
    logic  reseed;
    word_t seed_first;
    word_t seed_second;
    logic  step;
  } gen_ctrl_t;

  // smallest all-ones value not below x
  function automatic word_t smear_ones(word_t x);
    word_t m;
    m = x;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return m;
  endfunction

  function automatic word_t rotl(word_t x, int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

endpackage

// ----- rtl/xrr_req_if.sv -----
// request channel: range bounds
interface xrr_req_if;
  logic           valid;
  logic           ready;
  xrr_pkg::sword_t low_bound;
  xrr_pkg::sword_t high_bound;

  modport source (output valid, output low_bound, output high_bound, input ready);
  modport sink   (input valid, input low_bound, input high_bound, output ready);
endinterface

// ----- rtl/xrr_rsp_if.sv -----
// response channel: ranged random value
interface xrr_rsp_if;
  logic           valid;
  logic           ready;
  xrr_pkg::sword_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ----- rtl/xrr_alu.sv -----
// shared 64-bit add / subtract unit with borrow out
module xrr_alu (
  input  xrr_pkg::alu_op_e op_i,
  input  xrr_pkg::word_t   a_i,
  input  xrr_pkg::word_t   b_i,
  output xrr_pkg::word_t   res_o,
  output logic             borrow_o
);
  import xrr_pkg::*;

  logic              sub;
  logic [WordW:0]    sum;

  assign sub = (op_i == ALU_SUB);
  assign sum = {1'b0, a_i} + {1'b0, (b_i ^ {WordW{sub}})} + {{WordW{1'b0}}, sub};
  assign res_o    = sum[WordW-1:0];
  // a - b borrows when b > a
  assign borrow_o = sub & ~sum[WordW];
endmodule

// ----- rtl/xrr_gen.sv -----
// xoshiro256 state words, seeding sweep and per-step word capture
module xrr_gen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xrr_pkg::gen_ctrl_t ctrl_i,
  output xrr_pkg::word_t     draw_w1_o,
  output logic               busy_o
);
  import xrr_pkg::*;

  word_t [3:0]          w_q, w_d, w_step;
  logic [SeedCntW-1:0]  cnt_q, cnt_d;
  word_t                draw_q;
  logic                 adv;

  always_comb begin
    word_t t2, t3;
    t2 = w_q[2] ^ w_q[0];
    t3 = w_q[3] ^ w_q[1];
    w_step[0] = w_q[0] ^ t3;
    w_step[1] = w_q[1] ^ t2;
    w_step[2] = t2 ^ (w_q[1] << 17);
    w_step[3] = rotl(t3, 45);
  end

  assign busy_o = (cnt_q != '0);
  assign adv    = busy_o | ctrl_i.step;

  always_comb begin
    w_d   = w_q;
    cnt_d = cnt_q;
    if (ctrl_i.reseed) begin
      w_d[0] = ctrl_i.seed_first;
      w_d[1] = SeedFill;
      w_d[2] = ctrl_i.seed_second;
      w_d[3] = '0;
      cnt_d  = SeedCntW'(SeedSteps);
    end else if (adv) begin
      w_d = w_step;
      if (busy_o) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q[0] <= '0;
      w_q[1] <= SeedFill;
      w_q[2] <= '0;
      w_q[3] <= '0;
      cnt_q  <= SeedCntW'(SeedSteps);
    end else begin
      w_q   <= w_d;
      cnt_q <= cnt_d;
    end
  end

  // word one as it stood when the step was taken feeds the scrambler
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      draw_q <= w_q[1];
    end
  end

  assign draw_w1_o = draw_q;
endmodule

// ----- rtl/xoshiro_ranged_random_core.sv -----
// top level: ranged uniform random integers from a xoshiro256** generator
//
// usage
// - req channel carries low_bound / high_bound (inclusive, two's complement);
//   rsp channel returns random_value = low_bound + offset, wrapping mod 2^64
// - span = high_bound - low_bound mod 2^64; offset is a masked draw, redrawn
//   while it exceeds span unless span+1 is a power of two
// - one item is in flight at a time; after accept the states run SPAN, MUL5,
//   MUL9, CMP (skipped when span+1 is a power of two) and ADD, and every
//   rejected draw goes back through MUL5, MUL9 and CMP. The single shared
//   64-bit adder forms span, the *5 and *9 of the scrambler, the reject
//   compare and the final add one after another
// - a result sits in an output register; req is taken again while it waits,
//   and the sequencer holds in its last state only if a new result is ready
//   before the old one is taken
// - reset loads state {0, 0xff, 0, 0} and runs 16 generator steps
//   with req.ready low; a write to seed register 0 or 1 reseeds the same way,
//   other indexes are ignored
module xoshiro_ranged_random_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [xrr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  xrr_pkg::word_t               cfg_data_i,
  xrr_req_if.sink                      req,
  xrr_rsp_if.source                    rsp
);
  import xrr_pkg::*;

  // seed registers
  word_t seed_first_q, seed_second_q;
  gen_ctrl_t gen_ctrl;
  word_t     draw_w1;
  logic      gen_busy;

  // sequencer
  xrr_state_e state_q, state_d;

  // datapath registers
  word_t low_q, high_q, span_q, mask_q, acc_q;
  logic  pow2_q;
  word_t out_q;
  logic  out_valid_q;

  // shared adder
  alu_op_e alu_op;
  word_t   alu_a, alu_b, alu_res;
  logic    alu_borrow;

  logic req_take, out_free, rot_ok;
  word_t rot7, mask_new;

  assign out_free = !out_valid_q || rsp.ready;
  assign req_take = req.valid && req.ready;
  assign rot7     = rotl(acc_q, 7);
  assign mask_new = smear_ones(span_q);
  assign rot_ok   = 1'b1;

  // seed writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgSeedFirst) begin
        seed_first_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgSeedSecond) begin
        seed_second_q <= cfg_data_i;
      end
    end
  end

  xrr_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (gen_ctrl),
    .draw_w1_o (draw_w1),
    .busy_o    (gen_busy)
  );

  xrr_alu u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: state_d = ST_MUL5;
      ST_MUL5: state_d = ST_MUL9;
      ST_MUL9: state_d = pow2_q ? ST_ADD : ST_CMP;
      ST_CMP:  state_d = alu_borrow ? ST_MUL5 : ST_ADD;
      ST_ADD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs and adder operands
  always_comb begin
    logic written;
    written = cfg_we_i &&
              ((cfg_index_i == CfgSeedFirst) || (cfg_index_i == CfgSeedSecond));
    gen_ctrl.reseed      = written;
    gen_ctrl.seed_first  = (cfg_index_i == CfgSeedFirst) ? cfg_data_i : seed_first_q;
    gen_ctrl.seed_second = (cfg_index_i == CfgSeedSecond) ? cfg_data_i : seed_second_q;
    gen_ctrl.step        = 1'b0;
    req.ready            = 1'b0;
    alu_op               = ALU_ADD;
    alu_a                = low_q;
    alu_b                = acc_q;
    case (state_q)
      ST_IDLE: begin
        req.ready     = !gen_busy;
        // same condition as an accepted item
        gen_ctrl.step = req.valid && !gen_busy;
      end
      ST_SPAN: begin
        alu_op = ALU_SUB;
        alu_a  = high_q;
        alu_b  = low_q;
      end
      ST_MUL5: begin
        // w1 * 5
        alu_a = draw_w1 << 2;
        alu_b = draw_w1;
      end
      ST_MUL9: begin
        // rotl(w1 * 5, 7) * 9
        alu_a = rot7 << 3;
        alu_b = rot7;
      end
      ST_CMP: begin
        // span - r borrows when the draw is out of range: redraw
        alu_op        = ALU_SUB;
        alu_a         = span_q;
        alu_b         = acc_q;
        gen_ctrl.step = alu_borrow;
      end
      ST_ADD: begin
        alu_a = low_q;
        alu_b = acc_q;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_ADD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      low_q  <= req.low_bound;
      high_q <= req.high_bound;
    end
    if (state_q == ST_SPAN) begin
      span_q <= alu_res;
    end
    if (state_q == ST_MUL5) begin
      acc_q  <= alu_res;
      mask_q <= mask_new;
      pow2_q <= (mask_new == span_q);
    end
    if ((state_q == ST_MUL9) && rot_ok) begin
      acc_q <= alu_res & mask_q;
    end
    if ((state_q == ST_ADD) && out_free) begin
      out_q <= alu_res;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.random_value = out_q;
endmodule

// ----- tb/xrr_checker.sv -----
// scoreboard for the ranged random core: tracks seeds, predicts each value, compares
`timescale 1ns / 100ps

module xrr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [xrr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  xrr_pkg::word_t              cfg_data_i,
  xrr_req_if                          req,
  xrr_rsp_if                          rsp,
  output int                          mismatch_count_o,
  output int                          pending_o
);
  import xrr_pkg::*;

  word_t gen_words [4];
  word_t seed_first_q;
  word_t seed_second_q;
  word_t expected_values [$];
  word_t want;
  int    mismatches;

  function automatic word_t rotate_up(word_t x, int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // one xoshiro256** step, returns the scrambled output
  function automatic word_t advance_generator();
    word_t s0, s1, s2, s3, prod, out;
    s0 = gen_words[0];
    s1 = gen_words[1];
    s2 = gen_words[2] ^ s0;
    s3 = gen_words[3] ^ s1;
    prod = s1 * 64'd5;
    out = rotate_up(prod, 7) * 64'd9;
    gen_words[0] = s0 ^ s3;
    gen_words[1] = s1 ^ s2;
    gen_words[2] = s2 ^ (s1 << 17);
    gen_words[3] = rotate_up(s3, 45);
    return out;
  endfunction

  function automatic void restart_generator();
    word_t discard;
    gen_words[0] = seed_first_q;
    gen_words[1] = 64'h0000_0000_0000_00ff;
    gen_words[2] = seed_second_q;
    gen_words[3] = '0;
    for (int k = 0; k < 16; k++) discard = advance_generator();
  endfunction

  // low plus a uniform offset in [0, span], span taken mod 2^64
  function automatic word_t ranged_value(word_t low, word_t high);
    word_t span, mask, r;
    int unsigned sh;
    span = high - low;
    r = advance_generator();
    if ((span & (span + 64'd1)) == '0) begin
      r &= span;
    end else begin
      mask = span;
      for (sh = 1; sh < 64; sh = sh * 2) mask |= mask >> sh;
      r &= mask;
      while (r > span) r = advance_generator() & mask;
    end
    return r + low;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q = '0;
      seed_second_q = '0;
      restart_generator();
      expected_values.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgSeedFirst) begin
          seed_first_q = cfg_data_i;
          restart_generator();
        end else if (cfg_index_i == CfgSeedSecond) begin
          seed_second_q = cfg_data_i;
          restart_generator();
        end
      end
      if (req.valid && req.ready)
        expected_values.push_back(ranged_value(req.low_bound, req.high_bound));
      if (rsp.valid && rsp.ready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: random_value expected none, got %h", $time, rsp.random_value);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (rsp.random_value !== want) begin
            $display("%0t: random_value expected %h, got %h", $time, want,
                     rsp.random_value);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_values.size();
    end
  end

endmodule

// ----- tb/xoshiro_ranged_random_core_tb.sv -----
// top of the testbench: clock, reset, seed writes, range requests and the verdict
`timescale 1ns / 100ps

module xoshiro_ranged_random_core_tb;
  import xrr_pkg::*;

  // indexes with no register behind them, writes must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnusedLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHigh = 2'd3;

  localparam sword_t BoundMin = 64'h8000_0000_0000_0000;
  localparam sword_t BoundMax = 64'h7fff_ffff_ffff_ffff;

  localparam int PhaseItems  = 230;
  localparam int QuietItems  = 100;
  localparam int HoldCycles  = 300;
  localparam int EndSettle   = 20;
  localparam int RunLimitNs  = 2_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  word_t                cfg_data;
  int                   mismatches;
  int                   pending;
  bit                   quiet = 1'b0;     // no idling on either side while set
  bit                   hold_rsp = 1'b0;  // asks the receiver for one long hold-off

  xrr_req_if req_ch ();
  xrr_rsp_if rsp_ch ();

  xoshiro_ranged_random_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  xrr_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(RunLimitNs);
    $display("xoshiro_ranged_random_core: mismatch");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        // counted here so the sender keeps offering items meanwhile
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // offer one item, with random idle cycles ahead of it, and wait for accept
  task automatic send_bounds(input sword_t lo, input sword_t hi);
    while (!quiet && $urandom_range(99) < 22) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.low_bound  <= lo;
    req_ch.high_bound <= hi;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // random bounds, shaped by span class so every decision path gets traffic
  task automatic send_random();
    word_t base;
    word_t span;
    base = {$urandom, $urandom};
    // now and then pin the low bound to an extreme
    case ($urandom_range(9))
      0: base = BoundMin;
      1: base = BoundMax;
      default: ;
    endcase
    case ($urandom_range(7))
      0: span = 64'($urandom_range(300));                    // narrow range
      1: span = (64'd1 << $urandom_range(63)) - 64'd1;       // span+1 power of two
      2: span = 64'd1 << $urandom_range(63);                 // worst case rejection
      3: span = {$urandom, $urandom} >> $urandom_range(63);  // random width
      4: span = '1;                                          // full range
      5: span = 64'd0 - 64'($urandom_range(300, 1));         // reversed bounds
      default: span = {$urandom, $urandom};                  // unrelated bounds
    endcase
    send_bounds(base, base + span);
  endtask

  // wait until every accepted item has its value back
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // reseed through both registers, then poke an index that must be ignored
  task automatic reseed_with(input word_t first, input word_t second,
                             input logic [CfgIdxW-1:0] stray);
    cfg_we    <= 1'b1;
    cfg_index <= CfgSeedFirst;
    cfg_data  <= first;
    @(posedge clk_i);
    cfg_index <= CfgSeedSecond;
    cfg_data  <= second;
    @(posedge clk_i);
    cfg_index <= stray;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CfgSeedFirst;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.low_bound  = '0;
    req_ch.high_bound = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items on the reset seed; the block is still seeding, ready tells us when
    send_bounds(BoundMin, BoundMax);            // full range
    send_bounds(64'sd0, -64'sd1);               // full range through wrap
    send_bounds(BoundMax, BoundMin);            // reversed, span of one
    send_bounds(64'sd0, 64'sd0);                // single value
    send_bounds(BoundMax, BoundMax);
    send_bounds(BoundMin, BoundMin);
    send_bounds(-64'sd1, 64'sd0);
    send_bounds(64'sd0, 64'sd2);                // smallest span that can reject
    send_bounds(64'sd0, BoundMin);              // span 2^63, rejects about half
    send_bounds(64'sd5, 64'sd4);                // reversed, span all ones
    send_bounds(64'sd10, 64'sd3);               // reversed, wide wrapped span
    send_bounds(-64'sd5, 64'sd5);
    send_bounds(64'sd0, 64'sd255);              // power-of-two range
    send_bounds(64'sd100, 64'sd355);
    send_bounds(BoundMin, -64'sd1);             // span 2^63-1
    send_bounds(64'sd0, BoundMax);
    send_bounds(BoundMax, BoundMax - 64'sd2);   // reversed, sum wraps past max
    send_bounds(-64'sd3, BoundMax);             // span just above 2^63
    send_bounds(BoundMax - 64'sd1, BoundMin + 64'sd1);  // wrapped power-of-two span
    send_bounds(64'sd0, 64'sd6);
    req_ch.valid <= 1'b0;
    drain();

    // all-ones / zero seeds; the first stretch runs with no idling at all
    reseed_with('1, '0, CfgUnusedHigh);
    quiet = 1'b1;
    for (int n = 0; n < PhaseItems; n++) begin
      if (n == QuietItems) quiet = 1'b0;
      send_random();
    end
    req_ch.valid <= 1'b0;
    drain();

    // zero / all-ones seeds; receiver holds off while the sender keeps pushing
    reseed_with('0, '1, CfgUnusedLow);
    for (int n = 0; n < PhaseItems; n++) begin
      if (n == 20) hold_rsp = 1'b1;
      send_random();
    end
    req_ch.valid <= 1'b0;
    drain();

    // random seeds; the sender stops halfway until everything has come back
    reseed_with({$urandom, $urandom}, {$urandom, $urandom}, CfgUnusedHigh);
    for (int n = 0; n < PhaseItems; n++) begin
      if (n == PhaseItems / 2) begin
        req_ch.valid <= 1'b0;
        drain();
      end
      send_random();
    end
    req_ch.valid <= 1'b0;
    drain();

    // give a stray extra result time to show up
    repeat (EndSettle) @(posedge clk_i);
    if (mismatches == 0)
      $display("xoshiro_ranged_random_core: match");
    else
      $display("xoshiro_ranged_random_core: mismatch");
    $finish;
  end

endmodule
